// ===== src/sclacc_pkg.sv =====
`default_nettype none
package sclacc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ACC_W     = 48;
  localparam int SAT_W     = ACC_W + 3;
  localparam int PROD_W    = 2 * ACC_W;
  localparam int MUL_STEP  = 16;
  localparam int MUL_N     = ACC_W / MUL_STEP;
  localparam int MUL_CNT_W = $clog2(MUL_N + 1);
  localparam int K_W       = FRAC_BITS + 2;
  localparam int TAU_W     = FRAC_BITS + 1;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 31;
  localparam int IN_DATA_W  = 160;
  localparam int OUT_DATA_W = 6 * ACC_W;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RECIP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TAU   = 2'd2;

  localparam logic [16:0] Q_ONE = 17'h10000;
  localparam logic signed [ACC_W-1:0] ONE_ACC =
    {{(ACC_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [K_W-1:0] ONE_K =
    {1'b0, 1'b1, {FRAC_BITS{1'b0}}};

  typedef enum logic [1:0] {
    REG_OUT_LO,
    REG_IN_NEG,
    REG_IN_POS,
    REG_OUT_HI
  } region_t;

  typedef struct packed {
    logic [30:0] width;
    logic [30:0] recip;
    logic [16:0] qlevel;
  } cfg_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] r;
    region_t                 region;
    logic signed [K_W-1:0]   k;
    logic [30:0]             w;
    logic signed [31:0]      lpsi;
    logic [30:0]             e;
    logic                    last;
  } work_t;

  function automatic logic signed [SAT_W-1:0] ext_acc(input logic signed [ACC_W-1:0] v);
    return {{(SAT_W-ACC_W){v[ACC_W-1]}}, v};
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SAT_W-1:0] v);
    logic all1;
    logic all0;
    all1 = &v[SAT_W-1:ACC_W-1];
    all0 = ~|v[SAT_W-1:ACC_W-1];
    if (v[SAT_W-1] && !all1) return {1'b1, {(ACC_W-1){1'b0}}};
    if (!v[SAT_W-1] && !all0) return {1'b0, {(ACC_W-1){1'b1}}};
    return v[ACC_W-1:0];
  endfunction

  function automatic logic signed [ACC_W-1:0] sadd(input logic signed [ACC_W-1:0] a,
                                                  input logic signed [ACC_W-1:0] b);
    return sat_acc(ext_acc(a) + ext_acc(b));
  endfunction

  // drop fraction bits of an unsigned product, saturate and apply sign
  function automatic logic signed [ACC_W-1:0] qsat(input logic neg,
                                                  input logic [PROD_W-1:0] prod);
    logic [ACC_W-1:0] mid;
    logic [ACC_W-1:0] lim;
    logic [ACC_W-1:0] mag;
    logic             hi_nz;
    hi_nz = |prod[PROD_W-1:FRAC_BITS+ACC_W];
    mid   = prod[FRAC_BITS+ACC_W-1:FRAC_BITS];
    lim   = neg ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    mag   = (hi_nz || mid > lim) ? lim : mid;
    return neg ? signed'(ACC_W'(-mag)) : signed'(mag);
  endfunction

  function automatic logic [TAU_W-1:0] tau_of(input logic [16:0] qlevel);
    logic [16:0]            tq;
    logic [16+FRAC_BITS:0]  sh;
    tq = (qlevel > Q_ONE) ? Q_ONE : qlevel;
    sh = {tq, {FRAC_BITS{1'b0}}};
    return sh[16+FRAC_BITS:16];
  endfunction

endpackage
`default_nettype wire

// ===== src/sclacc_qmul.sv =====
`default_nettype none
module sclacc_qmul import sclacc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [ACC_W-1:0] a,
  input  logic signed [ACC_W-1:0] b,
  output logic                    busy,
  output logic                    done,
  output logic signed [ACC_W-1:0] y
);

  logic                    busy_r;
  logic                    done_r;
  logic [MUL_CNT_W-1:0]    cnt_r;
  logic                    neg_r;
  logic [ACC_W-1:0]        ua_r;
  logic [ACC_W-1:0]        ub_r;
  logic [PROD_W-1:0]       acc_r;
  logic signed [ACC_W-1:0] y_r;
  logic [ACC_W+MUL_STEP-1:0] pp;

  // one 16-bit slice of b per cycle, top slice first
  assign pp = ua_r * ub_r[ACC_W-1 -: MUL_STEP];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        neg_r  <= a[ACC_W-1] != b[ACC_W-1];
        ua_r   <= a[ACC_W-1] ? ACC_W'(-a) : a;
        ub_r   <= b[ACC_W-1] ? ACC_W'(-b) : b;
        acc_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (cnt_r < MUL_CNT_W'(MUL_N)) begin
          acc_r <= (acc_r << MUL_STEP) + PROD_W'(pp);
          ub_r  <= ub_r << MUL_STEP;
          cnt_r <= cnt_r + 1'b1;
        end else begin
          y_r    <= qsat(neg_r, acc_r);
          done_r <= 1'b1;
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign y    = y_r;

endmodule
`default_nettype wire

// ===== src/sclacc_front.sv =====
`default_nettype none
module sclacc_front import sclacc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic                 in_tlast,
  input  cfg_t                 cfg,
  input  logic                 q_full,
  output logic                 q_push,
  output work_t                q_din
);

  logic               s1_valid_r;
  logic signed [31:0] y_r;
  logic [30:0]        w_r;
  logic signed [31:0] mu_r;
  logic signed [31:0] lpsi_r;
  logic [30:0]        e_r;
  logic               last_r;

  logic signed [32:0]      diff;
  logic                    neg;
  logic [32:0]             mag;
  logic [63:0]             prod;
  logic signed [ACC_W-1:0] r;
  logic signed [ACC_W-1:0] cx;
  logic [TAU_W-1:0]        tau;
  logic signed [K_W-1:0]   tau_k;
  region_t                 region;
  logic signed [K_W-1:0]   k;

  assign q_push    = s1_valid_r && !q_full;
  assign in_tready = !s1_valid_r || q_push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        s1_valid_r <= 1'b1;
        y_r    <= in_tdata[31:0];
        w_r    <= in_tdata[62:32];
        mu_r   <= in_tdata[94:63];
        lpsi_r <= in_tdata[126:95];
        e_r    <= in_tdata[157:127];
        last_r <= in_tlast;
      end else if (q_push) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // scaled residual r = (y - mu) * e
  always_comb begin
    diff  = {y_r[31], y_r} - {mu_r[31], mu_r};
    neg   = diff[32];
    mag   = neg ? 33'(-diff) : diff;
    prod  = mag * e_r;
    r     = qsat(neg, PROD_W'(prod));
    cx    = {{(ACC_W-31){1'b0}}, cfg.width};
    tau   = tau_of(cfg.qlevel);
    tau_k = {1'b0, tau};
    if (r <= -cx) begin
      region = REG_OUT_LO;
      k      = tau_k - ONE_K;
    end else if (r > cx) begin
      region = REG_OUT_HI;
      k      = tau_k;
    end else if (r < 0) begin
      region = REG_IN_NEG;
      k      = ONE_K - tau_k;
    end else begin
      region = REG_IN_POS;
      k      = tau_k;
    end
  end

  always_comb begin
    q_din.r      = r;
    q_din.region = region;
    q_din.k      = k;
    q_din.w      = w_r;
    q_din.lpsi   = lpsi_r;
    q_din.e      = e_r;
    q_din.last   = last_r;
  end

endmodule
`default_nettype wire

// ===== src/sclacc_queue.sv =====
`default_nettype none
module sclacc_queue import sclacc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  work_t din,
  output logic  full,
  input  logic  pop,
  output work_t dout,
  output logic  empty
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  work_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wptr_r;
  logic [PTR_W-1:0] rptr_r;
  logic [PTR_W:0]   count_r;

  assign full  = count_r == (PTR_W+1)'(DEPTH);
  assign empty = count_r == '0;
  assign dout  = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        mem_r[wptr_r] <= din;
        wptr_r        <= wptr_r + 1'b1;
      end
      if (pop) rptr_r <= rptr_r + 1'b1;
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== src/sclacc_back.sv =====
`default_nettype none
module sclacc_back import sclacc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  work_t                 q_data,
  output logic                  q_pop,
  input  cfg_t                  cfg,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  typedef enum logic [1:0] {B_IDLE, B_ISSUE, B_WAIT, B_EMIT} bstate_t;
  typedef enum logic [4:0] {
    S_TERM, S_G, S_S,
    S_KR, S_T1, S_A, S_T2, S_B, S_T3, S_T4, S_H,
    S_WL, S_WT, S_WGM, S_WGS, S_WHMM, S_WHMS, S_WHSS
  } step_t;

  bstate_t                 state_r;
  step_t                   step_r;
  step_t                   step_nxt;
  work_t                   item_r;
  logic signed [ACC_W-1:0] term_r, ga_r, sb_r, kr_r, t_r, h_r, p_r;
  logic signed [ACC_W-1:0] loss_r, gm_acc_r, gs_acc_r, hmm_acc_r, hms_acc_r, hss_acc_r;
  logic                    out_valid_r;
  logic [OUT_DATA_W-1:0]   out_data_r;

  logic                    mul_start, mul_busy, mul_done;
  logic signed [ACC_W-1:0] mul_a, mul_b, mul_y;

  logic                    outer;
  logic signed [ACC_W-1:0] kx, k2x, ex, wx, lx, cix, cx, rr;
  logic signed [ACC_W-1:0] edge_arg, gm_v, gs_v, hmm_v, hms_v, hss_v;

  sclacc_qmul u_qmul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .done  (mul_done),
    .y     (mul_y)
  );

  assign q_pop     = (state_r == B_IDLE) && q_valid;
  assign mul_start = state_r == B_ISSUE;

  always_comb begin
    outer = item_r.region == REG_OUT_LO || item_r.region == REG_OUT_HI;
    kx    = {{(ACC_W-K_W){item_r.k[K_W-1]}}, item_r.k};
    k2x   = kx <<< 1;
    ex    = {{(ACC_W-31){1'b0}}, item_r.e};
    wx    = {{(ACC_W-31){1'b0}}, item_r.w};
    lx    = {{(ACC_W-32){item_r.lpsi[31]}}, item_r.lpsi};
    cix   = {{(ACC_W-31){1'b0}}, cfg.recip};
    cx    = {{(ACC_W-31){1'b0}}, cfg.width};
    rr    = item_r.r;
    edge_arg = (item_r.region == REG_OUT_LO) ? sat_acc((ext_acc(rr) <<< 1) + ext_acc(cx))
                                              : sat_acc((ext_acc(rr) <<< 1) - ext_acc(cx));
    gm_v  = outer ? sat_acc(-ext_acc(ga_r)) : sat_acc(-(ext_acc(ga_r) <<< 1));
    gs_v  = sadd(ONE_ACC, outer ? sat_acc(-ext_acc(sb_r)) : sat_acc(-(ext_acc(sb_r) <<< 1)));
    hmm_v = outer ? '0 : sat_acc(ext_acc(h_r) <<< 1);
    hms_v = outer ? ga_r : sat_acc(ext_acc(ga_r) <<< 2);
    hss_v = outer ? sb_r : sat_acc(ext_acc(sb_r) <<< 2);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_r)
      S_TERM: begin mul_a = kx;     mul_b = edge_arg; end
      S_G:    begin mul_a = k2x;    mul_b = ex;       end
      S_S:    begin mul_a = k2x;    mul_b = rr;       end
      S_KR:   begin mul_a = kx;     mul_b = rr;       end
      S_T1:   begin mul_a = kr_r;   mul_b = ex;       end
      S_A:    begin mul_a = t_r;    mul_b = cix;      end
      S_T2:   begin mul_a = kr_r;   mul_b = rr;       end
      S_B:    begin mul_a = t_r;    mul_b = cix;      end
      S_T3:   begin mul_a = kx;     mul_b = ex;       end
      S_T4:   begin mul_a = t_r;    mul_b = ex;       end
      S_H:    begin mul_a = t_r;    mul_b = cix;      end
      S_WL:   begin mul_a = wx;     mul_b = lx;       end
      S_WT:   begin mul_a = wx;     mul_b = term_r;   end
      S_WGM:  begin mul_a = wx;     mul_b = gm_v;     end
      S_WGS:  begin mul_a = wx;     mul_b = gs_v;     end
      S_WHMM: begin mul_a = wx;     mul_b = hmm_v;    end
      S_WHMS: begin mul_a = wx;     mul_b = hms_v;    end
      S_WHSS: begin mul_a = wx;     mul_b = hss_v;    end
      default: begin mul_a = '0;    mul_b = '0;       end
    endcase
  end

  always_comb begin
    case (step_r)
      S_TERM:  step_nxt = S_G;
      S_G:     step_nxt = S_S;
      S_S:     step_nxt = S_WL;
      S_KR:    step_nxt = S_T1;
      S_T1:    step_nxt = S_A;
      S_A:     step_nxt = S_T2;
      S_T2:    step_nxt = S_B;
      S_B:     step_nxt = S_T3;
      S_T3:    step_nxt = S_T4;
      S_T4:    step_nxt = S_H;
      S_H:     step_nxt = S_WL;
      S_WL:    step_nxt = S_WT;
      S_WT:    step_nxt = S_WGM;
      S_WGM:   step_nxt = S_WGS;
      S_WGS:   step_nxt = S_WHMM;
      S_WHMM:  step_nxt = S_WHMS;
      S_WHMS:  step_nxt = S_WHSS;
      default: step_nxt = S_WHSS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      step_r      <= S_TERM;
      out_valid_r <= 1'b0;
      loss_r      <= '0;
      gm_acc_r    <= '0;
      gs_acc_r    <= '0;
      hmm_acc_r   <= '0;
      hms_acc_r   <= '0;
      hss_acc_r   <= '0;
    end else begin
      // the emit state reloads the output word itself
      if (out_valid_r && out_tready && state_r != B_EMIT) out_valid_r <= 1'b0;
      case (state_r)
        B_IDLE: begin
          if (q_valid) begin
            item_r  <= q_data;
            step_r  <= (q_data.region == REG_OUT_LO || q_data.region == REG_OUT_HI)
                       ? S_TERM : S_KR;
            state_r <= B_ISSUE;
          end
        end
        B_ISSUE: state_r <= B_WAIT;
        B_WAIT: begin
          if (mul_done) begin
            case (step_r)
              S_TERM: term_r <= mul_y;
              S_G:    ga_r   <= mul_y;
              S_S:    sb_r   <= mul_y;
              S_KR:   kr_r   <= mul_y;
              S_T1:   t_r    <= mul_y;
              S_A:    ga_r   <= mul_y;
              S_T2:   t_r    <= mul_y;
              S_B: begin
                sb_r   <= mul_y;
                term_r <= mul_y;
              end
              S_T3:   t_r    <= mul_y;
              S_T4:   t_r    <= mul_y;
              S_H:    h_r    <= mul_y;
              S_WL:   p_r    <= mul_y;
              S_WT:   loss_r    <= sadd(loss_r, sadd(p_r, mul_y));
              S_WGM:  gm_acc_r  <= sadd(gm_acc_r, mul_y);
              S_WGS:  gs_acc_r  <= sadd(gs_acc_r, mul_y);
              S_WHMM: hmm_acc_r <= sadd(hmm_acc_r, mul_y);
              S_WHMS: hms_acc_r <= sadd(hms_acc_r, mul_y);
              S_WHSS: hss_acc_r <= sadd(hss_acc_r, mul_y);
              default: p_r <= mul_y;
            endcase
            step_r <= step_nxt;
            if (step_r == S_WHSS) state_r <= item_r.last ? B_EMIT : B_IDLE;
            else state_r <= B_ISSUE;
          end
        end
        B_EMIT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {hss_acc_r, hms_acc_r, hmm_acc_r, gs_acc_r, gm_acc_r, loss_r};
            loss_r      <= '0;
            gm_acc_r    <= '0;
            gs_acc_r    <= '0;
            hmm_acc_r   <= '0;
            hms_acc_r   <= '0;
            hss_acc_r   <= '0;
            state_r     <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_EMIT && (!out_valid_r || out_tready)) |=>
      (loss_r == '0 && gm_acc_r == '0 && gs_acc_r == '0 &&
       hmm_acc_r == '0 && hms_acc_r == '0 && hss_acc_r == '0))
    else $error("accumulators not cleared after emit");
  a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    mul_start |-> !mul_busy)
    else $error("multiplier started while busy");
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> state_r == B_WAIT)
    else $error("multiplier result outside wait state");
`endif

endmodule
`default_nettype wire

// ===== src/smoothed_check_loss_accumulator.sv =====
`default_nettype none
// channel  | direction | handshake            | payload
// in_      | input     | in_tvalid/in_tready  | in_tdata, in_tlast (last_obs)
// out_     | output    | out_tvalid/out_tready| out_tdata (six 48-bit sums)
// cfg_     | input     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// the back shares one multi-cycle multiplier for all its products
// an observation costs 10 products in the outer regions, 15 in the inner ones;
// after the last one the back emits the sums once out_ can take them
// synchronous active-low reset clears sums, queue and handshakes
// a 4-word queue lets the front accept while the back works or out_ stalls
module smoothed_check_loss_accumulator import sclacc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // obs_value[31:0], obs_weight[62:32], loc_mean[94:63], loc_log_scale[126:95],
  // loc_inv_scale[157:127], zero pad
  input  logic [IN_DATA_W-1:0]   in_tdata,
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // loss_sum, grad_mean, grad_log_scale, hess_mean_mean, hess_mean_scale,
  // hess_scale_scale, 48 bits each from bit 0 up
  output logic [OUT_DATA_W-1:0]  out_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t  cfg_r;
  logic  q_push, q_full, q_pop, q_empty;
  work_t q_din, q_dout;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width  <= 31'(ONE_ACC);
      cfg_r.recip  <= 31'(ONE_ACC);
      cfg_r.qlevel <= 17'h08000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IDX_WIDTH: cfg_r.width  <= cfg_data;
        CFG_IDX_RECIP: cfg_r.recip  <= cfg_data;
        CFG_IDX_TAU:   cfg_r.qlevel <= cfg_data[16:0];
        default:       cfg_r        <= cfg_r;
      endcase
    end
  end

  sclacc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .cfg       (cfg_r),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_din     (q_din)
  );

  sclacc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  sclacc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (!q_empty),
    .q_data     (q_dout),
    .q_pop      (q_pop),
    .cfg        (cfg_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none
module testbench import sclacc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint MAX48 = 64'sh7FFF_FFFF_FFFF;
  localparam longint MIN48 = -MAX48 - 1;
  localparam longint ONE = 64'sd1 << FRAC_BITS;
  localparam int SETTLE = 500;

  typedef struct {
    logic signed [31:0] y;
    logic [30:0]        w;
    logic signed [31:0] mu;
    logic signed [31:0] lpsi;
    logic [30:0]        e;
    logic               last;
  } obs_t;

  class loss_scoreboard;
    longint width_q, recip_q, level_q;
    longint loss_sum, gm_sum, gs_sum, hmm_sum, hms_sum, hss_sum;
    logic [OUT_DATA_W-1:0] sums_q[$];
    int errors;

    function new();
      width_q = ONE;
      recip_q = ONE;
      level_q = 32768;
      clear_sums();
      errors = 0;
    endfunction

    function void clear_sums();
      loss_sum = 0; gm_sum = 0; gs_sum = 0;
      hmm_sum = 0; hms_sum = 0; hss_sum = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_IDX_WIDTH: width_q = longint'(data);
        CFG_IDX_RECIP: recip_q = longint'(data);
        CFG_IDX_TAU:   level_q = longint'(data[16:0]);
        default: ;
      endcase
    endfunction

    function longint sat48(longint v);
      if (v > MAX48) return MAX48;
      if (v < MIN48) return MIN48;
      return v;
    endfunction

    function longint sadd(longint a, longint b);
      return sat48(sat48(a) + sat48(b));
    endfunction

    // exact product, truncate magnitude, saturate
    function longint qmul(longint a, longint b);
      longint ua, ub, lim;
      logic [127:0] p;
      logic neg;
      a = sat48(a);
      b = sat48(b);
      neg = (a < 0) != (b < 0);
      ua = a < 0 ? -a : a;
      ub = b < 0 ? -b : b;
      p = {64'b0, ua} * {64'b0, ub};
      p = p >> FRAC_BITS;
      lim = neg ? MAX48 + 1 : MAX48;
      if (p > 128'(lim)) p = 128'(lim);
      return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function void note_obs(obs_t o);
      longint y, mu, e, w, lpsi, c, tau, r, k, term, gm, gs, hmm, hms, hss, g, s, kr, a, b;
      region_t reg_r;
      y = longint'(o.y); mu = longint'(o.mu); e = longint'(o.e);
      w = longint'(o.w); lpsi = longint'(o.lpsi);
      c = width_q;
      tau = level_q > 65536 ? 65536 : level_q;
      r = qmul(y - mu, e);
      if (r <= -c) reg_r = REG_OUT_LO;
      else if (r > c) reg_r = REG_OUT_HI;
      else if (r < 0) reg_r = REG_IN_NEG;
      else reg_r = REG_IN_POS;
      if (reg_r == REG_OUT_LO || reg_r == REG_OUT_HI) begin
        if (reg_r == REG_OUT_LO) begin
          k = tau - ONE;
          term = qmul(k, sat48(2 * r + c));
        end else begin
          k = tau;
          term = qmul(k, sat48(2 * r - c));
        end
        g = qmul(2 * k, e);
        s = qmul(2 * k, r);
        gm = sat48(-g);
        gs = sadd(ONE, -s);
        hmm = 0;
        hms = g;
        hss = s;
      end else begin
        k = reg_r == REG_IN_NEG ? ONE - tau : tau;
        kr = qmul(k, r);
        a = qmul(qmul(kr, e), recip_q);
        b = qmul(qmul(kr, r), recip_q);
        term = b;
        gm = sat48(-2 * a);
        gs = sadd(ONE, sat48(-2 * b));
        hmm = sat48(2 * qmul(qmul(qmul(k, e), e), recip_q));
        hms = sat48(4 * a);
        hss = sat48(4 * b);
      end
      loss_sum = sadd(loss_sum, sadd(qmul(w, lpsi), qmul(w, term)));
      gm_sum = sadd(gm_sum, qmul(w, gm));
      gs_sum = sadd(gs_sum, qmul(w, gs));
      hmm_sum = sadd(hmm_sum, qmul(w, hmm));
      hms_sum = sadd(hms_sum, qmul(w, hms));
      hss_sum = sadd(hss_sum, qmul(w, hss));
      if (o.last) begin
        sums_q.push_back({hss_sum[47:0], hms_sum[47:0], hmm_sum[47:0],
                          gs_sum[47:0], gm_sum[47:0], loss_sum[47:0]});
        clear_sums();
      end
    endfunction

    function void check_sums(logic [OUT_DATA_W-1:0] got);
      logic [OUT_DATA_W-1:0] want;
      string names[6];
      names = '{"loss_sum", "grad_mean", "grad_log_scale", "hess_mean_mean",
                "hess_mean_scale", "hess_scale_scale"};
      if (sums_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %h", got);
        return;
      end
      want = sums_q.pop_front();
      for (int i = 0; i < 6; i++) begin
        if (got[48*i +: 48] !== want[48*i +: 48]) begin
          errors++;
          if (errors <= 10)
            $display("%s mismatch: expected %h actual %h", names[i],
                     want[48*i +: 48], got[48*i +: 48]);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int idle_pct = 0;
  int stall_pct = 0;
  loss_scoreboard sb = new();

  smoothed_check_loss_accumulator uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
    if (rst_n && in_tvalid && in_tready) begin
      obs_t o;
      o.y = in_tdata[31:0];
      o.w = in_tdata[62:32];
      o.mu = in_tdata[94:63];
      o.lpsi = in_tdata[126:95];
      o.e = in_tdata[157:127];
      o.last = in_tlast;
      sb.note_obs(o);
    end
    if (rst_n && out_tvalid && out_tready) sb.check_sums(out_tdata);
  end

  task automatic send_obs(obs_t o);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b0, o.e, o.lpsi, o.mu, o.w, o.y};
    in_tlast <= o.last;
    do @(posedge clk); while (!in_tready);
  endtask

  // drains results, then lets trailing non-last words finish
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.sums_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(int idx, longint data);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_data <= CFG_DATA_W'(data);
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(CFG_IDX_W'(idx), CFG_DATA_W'(data));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic obs_t rand_obs(logic last);
    obs_t o;
    if ($urandom_range(3) == 0) begin
      o.y = $urandom; o.mu = $urandom; o.lpsi = $urandom;
      o.w = 31'($urandom); o.e = 31'($urandom);
    end else begin
      o.mu = $signed($urandom_range(1 << 20)) - (1 << 19);
      o.y = o.mu + $signed($urandom_range(1 << 19)) - (1 << 18);
      o.lpsi = $signed($urandom_range(1 << 19)) - (1 << 18);
      o.w = 31'($urandom_range(1 << 18));
      o.e = 31'($urandom_range(1 << 17, 1 << 12));
    end
    if (o.e == 0) o.e = 1;
    o.last = last;
    return o;
  endfunction

  function automatic obs_t mk(longint y, longint w, longint mu, longint lpsi,
                              longint e, logic last);
    obs_t o;
    o.y = 32'(y); o.w = 31'(w); o.mu = 32'(mu); o.lpsi = 32'(lpsi); o.e = 31'(e);
    o.last = last;
    return o;
  endfunction

  initial begin
    int sent;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // residual regions, field extremes, zero weight, long and single locations
    send_obs(mk(-3 * ONE, ONE, 0, 0, ONE, 1'b1));
    send_obs(mk(-ONE / 2, ONE, 0, ONE, ONE, 1'b1));
    send_obs(mk(0, ONE, 0, -ONE, ONE, 1'b0));
    send_obs(mk(ONE / 2, 2 * ONE, 0, 0, ONE, 1'b0));
    send_obs(mk(ONE, ONE, 0, 0, ONE, 1'b0));
    send_obs(mk(-ONE, ONE, 0, 0, ONE, 1'b1));
    send_obs(mk(5 * ONE, ONE, 0, 0, 2 * ONE, 1'b1));
    send_obs(mk(32'sh7FFF_FFFF, 31'h7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                31'h7FFF_FFFF, 1'b1));
    send_obs(mk(32'sh8000_0000, 31'h7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
                31'h7FFF_FFFF, 1'b0));
    send_obs(mk(32'sh8000_0000, 31'h7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
                31'h7FFF_FFFF, 1'b1));
    send_obs(mk(ONE, 0, 0, 32'sh7FFF_FFFF, 1, 1'b1));
    send_obs(mk(ONE, 31'h7FFF_FFFF, 0, 32'sh7FFF_FFFF, 1, 1'b1));
    drain();
    // zero width and reciprocal, tau beyond one, a write to an unused index
    write_reg(CFG_IDX_WIDTH, 0);
    write_reg(CFG_IDX_RECIP, 0);
    write_reg(CFG_IDX_TAU, 17'h1FFFF);
    write_reg(3, 31'h7FFF_FFFF);
    send_obs(mk(0, ONE, 0, 0, ONE, 1'b1));
    send_obs(mk(1, ONE, 0, 0, ONE, 1'b1));
    send_obs(mk(-1, ONE, 0, 0, ONE, 1'b1));
    drain();
    write_reg(CFG_IDX_WIDTH, 31'h7FFF_FFFF);
    write_reg(CFG_IDX_RECIP, 31'h7FFF_FFFF);
    write_reg(CFG_IDX_TAU, 0);
    send_obs(mk(3 * ONE, ONE, 0, 0, ONE, 1'b1));
    send_obs(mk(-3 * ONE, ONE, 0, 0, ONE, 1'b1));
    send_obs(mk(32'sh7FFF_FFFF, ONE, 32'sh8000_0000, 0, 31'h7FFF_FFFF, 1'b1));
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 48; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 48; end
        default: begin idle_pct = 14; stall_pct = 14; end
      endcase
      case (ph)
        0: begin
          write_reg(CFG_IDX_WIDTH, ONE);
          write_reg(CFG_IDX_RECIP, ONE);
          write_reg(CFG_IDX_TAU, 32768);
        end
        1: begin
          write_reg(CFG_IDX_WIDTH, ONE / 4);
          write_reg(CFG_IDX_RECIP, 4 * ONE);
          write_reg(CFG_IDX_TAU, 65536);
        end
        2: begin
          write_reg(CFG_IDX_WIDTH, 4 * ONE);
          write_reg(CFG_IDX_RECIP, ONE / 4);
          write_reg(CFG_IDX_TAU, 0);
        end
        default: begin
          write_reg(CFG_IDX_WIDTH, $urandom_range(8 * ONE, 1));
          write_reg(CFG_IDX_RECIP, $urandom);
          write_reg(CFG_IDX_TAU, $urandom_range(17'h1FFFF));
        end
      endcase
      sent = 0;
      while (sent < 140) begin
        int len;
        len = $urandom_range(6, 1);
        for (int i = 0; i < len; i++) begin
          // a few locations are left open into the next one
          send_obs(rand_obs(i == len - 1 && $urandom_range(9) != 0));
          sent++;
        end
      end
      send_obs(rand_obs(1'b1));
      drain();
    end

    if (sb.errors == 0) $display("smoothed_check_loss_accumulator regression: pass");
    else $display("smoothed_check_loss_accumulator regression: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("smoothed_check_loss_accumulator regression: fail");
    $finish;
  end

endmodule
`default_nettype wire
